/* rtl/core/mdfb_pkg.sv */
// ============================================================================
// mdfb_pkg - motor drive frame builder shared definitions
// Command codes, frame constants, fixed-point scaling constants, the request
// passed from the scaling pipe to the byte serializer, and the CRC step.
// ============================================================================
package mdfb_pkg;

  // Input command codes; codes 5..7 are dropped
  typedef enum logic [2:0] {
    CMD_CURRENT  = 3'd0,
    CMD_VELOCITY = 3'd1,
    CMD_POSITION = 3'd2,
    CMD_BRAKE    = 3'd3,
    CMD_STATUS   = 3'd4
  } cmd_t;

  // Frame constants
  localparam logic [7:0] CODE_DRIVE  = 8'h64;
  localparam logic [7:0] CODE_STATUS = 8'h74;
  localparam logic [7:0] BRAKE_MARK  = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  // Clamp limits on the 17-bit signed target
  localparam logic signed [16:0] CUR_MAX = 17'sd8000;
  localparam logic signed [16:0] CUR_MIN = -17'sd8000;
  localparam logic signed [16:0] VEL_MAX = 17'sd300;
  localparam logic signed [16:0] VEL_MIN = -17'sd300;
  localparam logic signed [16:0] POS_MAX = 17'sd36000;
  localparam logic signed [16:0] POS_MIN = 17'sd0;

  // Current: |c|*32767/8000 = 4|c| + floor(767|c| / 8000), 8000 = 64 * 125
  localparam logic [9:0]  CUR_FRAC    = 10'd767;
  localparam logic [10:0] CUR_DIV     = 11'd125;
  localparam logic [25:0] CUR_RECIP   = 26'd34359738;   // floor(2^32 / 125)
  // Position: x - ceil(3233x / 36000), 36000 = 32 * 1125
  localparam logic [11:0] POS_COMP    = 12'd3233;
  localparam logic [15:0] POS_BIAS    = 16'd35999;
  localparam logic [10:0] POS_DIV     = 11'd1125;
  localparam logic [25:0] POS_RECIP   = 26'd3817748;    // floor(2^32 / 1125)

  // Quotient and dividend widths inside the scaling pipe
  localparam int unsigned DVD_W = 22;
  localparam int unsigned QUO_W = 12;

  // Request handed to the serializer: everything needed to form bytes 0..8
  typedef struct packed {
    logic [7:0]  motor_id;
    cmd_t        cmd;
    logic [15:0] word;
  } frame_req_t;

  // One byte of CRC-8/MAXIM (reflected); caller xors the data byte in first
  function automatic logic [7:0] crc8_step(input logic [7:0] din);
    logic [7:0] c;
    c = din;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/mdfb_ifs.sv */
// ============================================================================
// mdfb_ifs - motor drive frame builder channel interfaces
// Command channel and frame byte channel, valid/ready handshake.
// ============================================================================

// Command channel
interface mdfb_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [7:0]         motor_id;
  logic signed [16:0] target;

  modport source (output valid, output cmd, output motor_id, output target, input ready);
  modport sink   (input valid, input cmd, input motor_id, input target, output ready);
endinterface

// Frame byte channel
interface mdfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* rtl/core/mdfb_scale.sv */
// ============================================================================
// mdfb_scale - command target scaling pipe
// Three registered stages: input capture, clamp and constant multiply,
// reciprocal multiply, then remainder correction into the 16-bit target word.
// ============================================================================
module mdfb_scale (
  input  logic                clk,
  input  logic                rst_n,
  // command side
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_cmd,
  input  logic [7:0]          in_motor_id,
  input  logic signed [16:0]  in_target,
  // request side
  output logic                req_valid,
  input  logic                req_ready,
  output mdfb_pkg::frame_req_t req
);
  import mdfb_pkg::*;

  // stage registers
  logic               v1_r, v2_r, v3_r;
  cmd_t               cmd1_r, cmd2_r, cmd3_r;
  logic [7:0]         id1_r, id2_r, id3_r;
  logic signed [16:0] tgt1_r;
  logic [DVD_W-1:0]   w2_r, w3_r;
  logic [15:0]        base2_r, base3_r;
  logic               neg2_r, neg3_r;
  logic [QUO_W-1:0]   est3_r;

  logic rdy1, rdy2, rdy3;

  // stage 1 logic
  logic signed [16:0] cur_c, cur_abs, vel_c, pos_c;
  logic [12:0]        cur_mag;
  logic [22:0]        cur_prod;
  logic [15:0]        pos_x;
  logic [26:0]        pos_sum;
  logic [DVD_W-1:0]   w2_nxt;
  logic [15:0]        base2_nxt;

  // stage 2 logic
  logic [25:0]        recip;
  logic [47:0]        est_prod;

  // stage 3 logic
  logic [10:0]        div3;
  logic [DVD_W-1:0]   rem3;
  logic [QUO_W-1:0]   quo3;
  logic [15:0]        cur_sum;
  logic [15:0]        word3;

  // ready chain: a stage loads when it is empty or drains this cycle
  assign rdy3     = !v3_r || req_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: clamp, then scale numerator by a constant
  always_comb begin
    cur_c = (tgt1_r < CUR_MIN) ? CUR_MIN : ((tgt1_r > CUR_MAX) ? CUR_MAX : tgt1_r);
    vel_c = (tgt1_r < VEL_MIN) ? VEL_MIN : ((tgt1_r > VEL_MAX) ? VEL_MAX : tgt1_r);
    pos_c = (tgt1_r < POS_MIN) ? POS_MIN : ((tgt1_r > POS_MAX) ? POS_MAX : tgt1_r);
    cur_abs  = cur_c[16] ? -cur_c : cur_c;
    cur_mag  = cur_abs[12:0];
    cur_prod = 23'(cur_mag) * 23'(CUR_FRAC);
    pos_x    = pos_c[15:0];
    pos_sum  = 27'(pos_x) * 27'(POS_COMP) + 27'(POS_BIAS);
    w2_nxt    = '0;
    base2_nxt = '0;
    case (cmd1_r)
      CMD_CURRENT: begin
        w2_nxt    = DVD_W'(cur_prod[22:6]);
        base2_nxt = 16'({cur_mag, 2'b00});
      end
      CMD_VELOCITY: begin
        base2_nxt = vel_c[15:0];
      end
      CMD_POSITION: begin
        w2_nxt    = pos_sum[26:5];
        base2_nxt = pos_x;
      end
      default: begin
        w2_nxt    = '0;
        base2_nxt = '0;
      end
    endcase
  end

  // stage 2: quotient estimate by reciprocal, may be one low
  assign recip    = (cmd2_r == CMD_POSITION) ? POS_RECIP : CUR_RECIP;
  assign est_prod = 48'(w2_r) * 48'(recip);

  // stage 3: remainder check fixes the estimate, then form the word
  always_comb begin
    div3    = (cmd3_r == CMD_POSITION) ? POS_DIV : CUR_DIV;
    rem3    = w3_r - DVD_W'(est3_r) * DVD_W'(div3);
    quo3    = (rem3 >= DVD_W'(div3)) ? est3_r + QUO_W'(1) : est3_r;
    cur_sum = base3_r + 16'(quo3);
    case (cmd3_r)
      CMD_CURRENT:  word3 = neg3_r ? 16'(16'd0 - cur_sum) : cur_sum;
      CMD_VELOCITY: word3 = base3_r;
      CMD_POSITION: word3 = base3_r - 16'(quo3);
      default:      word3 = '0;
    endcase
  end

  assign req_valid    = v3_r;
  assign req.motor_id = id3_r;
  assign req.cmd      = cmd3_r;
  assign req.word     = word3;

  // valid bits; unused codes are taken and dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid && (in_cmd <= CMD_STATUS);
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1_r <= cmd_t'(in_cmd);
      id1_r  <= in_motor_id;
      tgt1_r <= in_target;
    end
    if (rdy2) begin
      cmd2_r  <= cmd1_r;
      id2_r   <= id1_r;
      w2_r    <= w2_nxt;
      base2_r <= base2_nxt;
      neg2_r  <= cur_c[16];
    end
    if (rdy3) begin
      cmd3_r  <= cmd2_r;
      id3_r   <= id2_r;
      w3_r    <= w2_r;
      est3_r  <= est_prod[32 +: QUO_W];
      base3_r <= base2_r;
      neg3_r  <= neg2_r;
    end
  end

endmodule

/* rtl/core/mdfb_serializer.sv */
// ============================================================================
// mdfb_serializer - frame byte serializer with running CRC
// Holds one frame request, sends bytes 0..8 one per handshake while the
// CRC-8 accumulates, then sends the CRC as the last byte.
// ============================================================================
module mdfb_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  // request side
  input  logic                 req_valid,
  output logic                 req_ready,
  input  mdfb_pkg::frame_req_t req,
  // byte side
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_frame_byte,
  output logic                 out_last_byte
);
  import mdfb_pkg::*;

  // byte positions in the frame
  localparam logic [3:0] IDX_ID    = 4'd0;
  localparam logic [3:0] IDX_CODE  = 4'd1;
  localparam logic [3:0] IDX_HI    = 4'd2;
  localparam logic [3:0] IDX_LO    = 4'd3;
  localparam logic [3:0] IDX_BRAKE = 4'd7;
  localparam logic [3:0] IDX_CRC   = 4'd9;

  frame_req_t  req_r;
  logic [3:0]  idx_r;
  logic [7:0]  crc_r;
  logic        busy_r;

  logic        out_fire;
  logic        at_crc;
  logic [7:0]  cur_byte;

  assign at_crc    = (idx_r == IDX_CRC);
  assign out_fire  = busy_r && out_ready;
  // next frame loads as the CRC byte leaves
  assign req_ready = !busy_r || (out_fire && at_crc);

  // byte select
  always_comb begin
    case (idx_r)
      IDX_ID:    cur_byte = req_r.motor_id;
      IDX_CODE:  cur_byte = (req_r.cmd == CMD_STATUS) ? CODE_STATUS : CODE_DRIVE;
      IDX_HI:    cur_byte = req_r.word[15:8];
      IDX_LO:    cur_byte = req_r.word[7:0];
      IDX_BRAKE: cur_byte = (req_r.cmd == CMD_BRAKE) ? BRAKE_MARK : 8'h00;
      IDX_CRC:   cur_byte = crc_r;
      default:   cur_byte = 8'h00;
    endcase
  end

  assign out_valid      = busy_r;
  assign out_frame_byte = cur_byte;
  assign out_last_byte  = at_crc;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= IDX_ID;
    end else if (req_valid && req_ready) begin
      busy_r <= 1'b1;
      idx_r  <= IDX_ID;
    end else if (out_fire) begin
      busy_r <= !at_crc;
      idx_r  <= at_crc ? IDX_ID : idx_r + 4'd1;
    end
  end

  // payload and CRC
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_r <= req;
      crc_r <= 8'h00;
    end else if (out_fire && !at_crc) begin
      crc_r <= crc8_step(crc_r ^ cur_byte);
    end
  end

endmodule

/* rtl/core/motor_drive_frame_builder_top.sv */
// ============================================================================
// motor_drive_frame_builder_top - RS485 motor command frame builder
// Turns each command into a 10-byte frame (address, code, big-endian target,
// padding, brake mark, padding, CRC-8/MAXIM) sent one byte per handshake.
// ============================================================================
//
//   channel  dir  payload                           completes on
//   in_ch    in   cmd[2:0] motor_id[7:0] target[16:0]  valid & ready
//   out_ch   out  frame_byte[7:0] last_byte           valid & ready
//
// A command passes three register stages (capture, clamp and scale, reciprocal
// estimate) and quotient correction, then loads into the serializer before
// its first byte is offered. The serializer sends one byte per cycle while
// out_ch is ready; the scaling stages keep taking commands meanwhile.
// Codes 5..7 are accepted and produce no bytes.
// Synchronous active-low reset clears the stage valid bits and the serializer.
// A stall on out_ch holds the current byte and backs up into in_ch.ready.
//
module motor_drive_frame_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  mdfb_cmd_if.sink    in_ch,
  mdfb_byte_if.source out_ch
);
  import mdfb_pkg::*;

  logic       req_valid;
  logic       req_ready;
  frame_req_t req;

  // target scaling pipe
  mdfb_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_cmd      (in_ch.cmd),
    .in_motor_id (in_ch.motor_id),
    .in_target   (in_ch.target),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req)
  );

  // byte serializer and CRC
  mdfb_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_frame_byte (out_ch.frame_byte),
    .out_last_byte  (out_ch.last_byte)
  );

endmodule

/* rtl/core/mdfb_checker.sv */
// ============================================================================
// mdfb_checker - port-level checks for the frame builder
// Watches the byte channel for frame framing and handshake behavior.
// ============================================================================
module mdfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_last_byte
);

  // stalled byte holds its value and marker
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) && $stable(out_last_byte))
    else $error("byte channel changed while stalled");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("byte offered right after reset");

  // a frame never starts with its last byte
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !out_last_byte)
    else $error("frame started on the CRC byte");

  // a frame keeps going until its last byte is taken
  a_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=> out_valid)
    else $error("frame ended before the CRC byte");

endmodule

bind motor_drive_frame_builder_top mdfb_checker u_mdfb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_frame_byte (out_ch.frame_byte),
  .out_last_byte  (out_ch.last_byte)
);
